/* hw/rtl/pcrs_pkg.sv */
package pcrs_pkg;

   localparam int MAX_TARGETS     = 4;
   localparam int MAX_DRAIN_WORDS = 65536;
   localparam int DRAIN_W         = $clog2(MAX_DRAIN_WORDS) + 1;
   localparam int RSP_DEPTH       = 10;
   localparam int RSP_CNT_W       = $clog2(RSP_DEPTH + 1);

   // request actions
   localparam logic [1:0] ACT_ENUMERATE = 2'd0;
   localparam logic [1:0] ACT_RESET     = 2'd1;
   localparam logic [1:0] ACT_REPLY     = 2'd2;
   localparam logic [1:0] ACT_TICK      = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_WRITE   = 3'd0;
   localparam logic [2:0] KIND_READ    = 3'd1;
   localparam logic [2:0] KIND_DISCARD = 3'd2;
   localparam logic [2:0] KIND_STALL   = 3'd3;
   localparam logic [2:0] KIND_TICK    = 3'd4;
   localparam logic [2:0] KIND_DONE    = 3'd5;
   localparam logic [2:0] KIND_FAIL    = 3'd6;

   // taskfile registers
   localparam logic [2:0] REG_STATUS  = 3'd0;
   localparam logic [2:0] REG_CNT_LO  = 3'd1;
   localparam logic [2:0] REG_CNT_HI  = 3'd2;
   localparam logic [2:0] REG_DRIVE   = 3'd3;
   localparam logic [2:0] REG_CONTROL = 3'd4;
   localparam logic [2:0] REG_DATA    = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_TARGET_COUNT = 3'd0;
   localparam logic [2:0] CSR_BAD_MASK     = 3'd1;
   localparam logic [2:0] CSR_SEL_TIMEOUT  = 3'd2;
   localparam logic [2:0] CSR_BSY_TIMEOUT  = 3'd3;
   localparam logic [2:0] CSR_SKIP_DRAIN   = 3'd4;

   localparam logic [7:0] STATUS_FLOAT    = 8'hFF;
   localparam logic [7:0] STATUS_FLOAT_LO = 8'h7F;
   localparam logic [7:0] ECHO_A          = 8'h55;
   localparam logic [7:0] ECHO_B          = 8'hAA;
   localparam logic [7:0] CTRL_SRST       = 8'h0C;
   localparam logic [7:0] CTRL_RUN        = 8'h08;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] read_value;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] reg_select;
      logic [7:0] write_value;
      logic [3:0] present_map;
      logic [1:0] failed_target;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [RSP_CNT_W-1:0]        count;
      rsp_type [RSP_DEPTH-1:0]     item;
   } rsp_batch_type;

   function automatic rsp_type mk_rsp(logic [2:0] kind, logic [2:0] reg_sel,
                                      logic [7:0] val, logic [3:0] map,
                                      logic [1:0] tgt);
      rsp_type r;
      r.kind          = kind;
      r.reg_select    = reg_sel;
      r.write_value   = val;
      r.present_map   = map;
      r.failed_target = tgt;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic rsp_batch_type rsp_push(rsp_batch_type b, rsp_type r);
      rsp_batch_type n;
      n = b;
      if (b.count < RSP_CNT_W'(RSP_DEPTH)) begin
         n.item[b.count] = r;
         n.count         = b.count + RSP_CNT_W'(1);
      end
      return n;
   endfunction

   function automatic logic [7:0] select_byte(logic [1:0] t);
      return {3'b101, t[0], 4'b0000};
   endfunction

endpackage

/* hw/rtl/pcrs_rsp_queue.sv */
module pcrs_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  pcrs_pkg::rsp_batch_type batch,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pcrs_pkg::rsp_type     rsp_payload
);

   pcrs_pkg::rsp_type [pcrs_pkg::RSP_DEPTH-1:0] item_ff, item_in;
   logic [pcrs_pkg::RSP_CNT_W-1:0]              count_ff, count_in;
   logic                                        pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = item_ff[0];
   assign pop         = rsp_valid && rsp_ready;
   assign can_load    = (count_ff == '0) ||
                        ((count_ff == pcrs_pkg::RSP_CNT_W'(1)) && rsp_ready);

   always_comb begin
      item_in  = item_ff;
      count_in = count_ff;
      if (load) begin
         item_in  = batch.item;
         count_in = batch.count;
      end else if (pop) begin
         for (int k = 0; k < pcrs_pkg::RSP_DEPTH - 1; k++) begin
            item_in[k] = item_ff[k+1];
         end
         count_in = count_ff - pcrs_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/pata_channel_reset_sequencer.sv */
// Host-side reset and enumeration sequencer for one parallel ATA channel. Each request
// (command, register read reply or timer tick) is captured in an input register, then
// evaluated combinationally; when taken, it updates the sequencer state and loads the
// whole list of bus operations it causes (up to ten) into the result queue. Results
// leave one per cycle while rsp_ready holds, so a request that causes n results holds the
// result port until all n are taken; the next request is evaluated once the queue is empty
// or its final result is being taken, which keeps one request per cycle flowing when each
// causes at most one result and rsp_ready holds. The queue drain sets the sustained rate.
module pata_channel_reset_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcrs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcrs_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_PR_STATUS,
      PH_PR_LOW,
      PH_PR_HIGH,
      PH_DR_STATUS,
      PH_RA_READ,
      PH_RA_TICK,
      PH_WB_READ,
      PH_WB_TICK
   } phase_type;

   // configuration
   logic [2:0]  target_count_ff;
   logic [3:0]  bad_mask_ff;
   logic [15:0] sel_timeout_ff;
   logic [15:0] bsy_timeout_ff;
   logic        skip_drain_ff;

   // sequencer state
   phase_type                     phase_ff, phase_in;
   logic [1:0]                    probe_ff, probe_in;
   logic [3:0]                    found_ff, found_in;
   logic [3:0]                    pending_ff, pending_in;
   logic [1:0]                    current_ff, current_in;
   logic [15:0]                   wait_ff, wait_in;
   logic [pcrs_pkg::DRAIN_W-1:0]  drain_ff, drain_in;
   logic                          rpass_ff, rpass_in;

   // input register
   logic              in_valid_ff;
   pcrs_pkg::req_type in_ff;

   pcrs_pkg::rsp_batch_type batch;
   logic                    can_load;
   logic                    take;
   logic [2:0]              limit;

   assign csr_ready = 1'b1;
   assign take      = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || take;
   assign limit     = (target_count_ff > 3'(pcrs_pkg::MAX_TARGETS)) ?
                      3'(pcrs_pkg::MAX_TARGETS) : target_count_ff;

   always_comb begin : step
      pcrs_pkg::rsp_batch_type b;
      logic       do_probe;
      logic       do_wait;
      logic       hit;
      logic [1:0] pick;
      logic [2:0] start;
      logic [2:0] next_t;
      logic [1:0] low_t;
      logic [7:0] v;

      b          = '0;
      do_probe   = 1'b0;
      do_wait    = 1'b0;
      hit        = 1'b0;
      pick       = 2'd0;
      start      = 3'd0;
      low_t      = 2'd0;
      v          = in_ff.read_value;
      next_t     = {1'b0, probe_ff} + 3'd1;
      phase_in   = phase_ff;
      probe_in   = probe_ff;
      found_in   = found_ff;
      pending_in = pending_ff;
      current_in = current_ff;
      wait_in    = wait_ff;
      drain_in   = drain_ff;
      rpass_in   = rpass_ff;

      unique case (in_ff.action)
         pcrs_pkg::ACT_ENUMERATE, pcrs_pkg::ACT_RESET: begin
            if (phase_ff == PH_IDLE) begin
               rpass_in = in_ff.action[0];
               found_in = 4'd0;
               start    = 3'd0;
               do_probe = 1'b1;
            end
         end
         pcrs_pkg::ACT_REPLY: begin
            unique case (phase_ff)
               PH_PR_STATUS: begin
                  if (v == pcrs_pkg::STATUS_FLOAT || v == pcrs_pkg::STATUS_FLOAT_LO) begin
                     start    = next_t;
                     do_probe = 1'b1;
                  end else begin
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                            pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_A, 4'd0, 2'd0));
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                            pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_B, 4'd0, 2'd0));
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                            pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_A, 4'd0, 2'd0));
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                            pcrs_pkg::REG_CNT_LO, 8'd0, 4'd0, 2'd0));
                     phase_in = PH_PR_LOW;
                  end
               end
               PH_PR_LOW: begin
                  if (v != pcrs_pkg::ECHO_A) begin
                     start    = next_t;
                     do_probe = 1'b1;
                  end else begin
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                            pcrs_pkg::REG_CNT_HI, pcrs_pkg::ECHO_B, 4'd0, 2'd0));
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                            pcrs_pkg::REG_CNT_HI, pcrs_pkg::ECHO_A, 4'd0, 2'd0));
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                            pcrs_pkg::REG_CNT_HI, pcrs_pkg::ECHO_B, 4'd0, 2'd0));
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                            pcrs_pkg::REG_CNT_HI, 8'd0, 4'd0, 2'd0));
                     phase_in = PH_PR_HIGH;
                  end
               end
               PH_PR_HIGH: begin
                  if (v != pcrs_pkg::ECHO_B) begin
                     start    = next_t;
                     do_probe = 1'b1;
                  end else begin
                     found_in = found_ff | (4'd1 << probe_ff);
                     if (rpass_ff && !skip_drain_ff) begin
                        drain_in = '0;
                        b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                               pcrs_pkg::REG_STATUS, 8'd0, 4'd0, 2'd0));
                        phase_in = PH_DR_STATUS;
                     end else begin
                        start    = next_t;
                        do_probe = 1'b1;
                     end
                  end
               end
               PH_DR_STATUS: begin
                  if (!v[3]) begin
                     start    = next_t;
                     do_probe = 1'b1;
                  end else begin
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_DISCARD,
                            pcrs_pkg::REG_DATA, 8'd0, 4'd0, 2'd0));
                     drain_in = drain_ff + pcrs_pkg::DRAIN_W'(1);
                     if (drain_in >= pcrs_pkg::DRAIN_W'(pcrs_pkg::MAX_DRAIN_WORDS)) begin
                        start    = next_t;
                        do_probe = 1'b1;
                     end else begin
                        b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                               pcrs_pkg::REG_STATUS, 8'd0, 4'd0, 2'd0));
                     end
                  end
               end
               PH_RA_READ: begin
                  if (v == pcrs_pkg::ECHO_B) begin
                     wait_in = bsy_timeout_ff;
                     b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                            pcrs_pkg::REG_STATUS, 8'd0, 4'd0, 2'd0));
                     phase_in = PH_WB_READ;
                  end else begin
                     wait_in = wait_ff - 16'd1;
                     if (wait_in != 16'd0) begin
                        b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_TICK,
                               3'd0, 8'd0, 4'd0, 2'd0));
                        phase_in = PH_RA_TICK;
                     end else begin
                        b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_FAIL,
                               3'd0, 8'd0, 4'd0, current_ff));
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_WB_READ: begin
                  if (!v[7] || v == pcrs_pkg::STATUS_FLOAT) begin
                     pending_in = pending_ff & ~(4'd1 << current_ff);
                     if (pending_in != 4'd0) begin
                        do_wait = 1'b1;
                     end else begin
                        rpass_in = 1'b0;
                        found_in = 4'd0;
                        start    = 3'd0;
                        do_probe = 1'b1;
                     end
                  end else begin
                     wait_in = wait_ff - 16'd1;
                     if (wait_in != 16'd0) begin
                        b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_TICK,
                               3'd0, 8'd0, 4'd0, 2'd0));
                        phase_in = PH_WB_TICK;
                     end else begin
                        b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_FAIL,
                               3'd0, 8'd0, 4'd0, current_ff));
                        phase_in = PH_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         pcrs_pkg::ACT_TICK: begin
            if (phase_ff == PH_RA_TICK) begin
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                      pcrs_pkg::REG_DRIVE, pcrs_pkg::select_byte(current_ff), 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                      pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_B, 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                      pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_A, 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                      pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_B, 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                      pcrs_pkg::REG_CNT_LO, 8'd0, 4'd0, 2'd0));
               phase_in = PH_RA_READ;
            end else if (phase_ff == PH_WB_TICK) begin
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                      pcrs_pkg::REG_STATUS, 8'd0, 4'd0, 2'd0));
               phase_in = PH_WB_READ;
            end
         end
         default: begin
         end
      endcase

      // Probe scan; an empty reset pass re-runs it once as a plain enumeration.
      for (int pass = 0; pass < 2; pass++) begin
         if (do_probe) begin
            hit  = 1'b0;
            pick = 2'd0;
            for (int i = pcrs_pkg::MAX_TARGETS - 1; i >= 0; i--) begin
               if (3'(i) >= start && 3'(i) < limit && !bad_mask_ff[i]) begin
                  hit  = 1'b1;
                  pick = 2'(i);
               end
            end
            do_probe = 1'b0;
            if (hit) begin
               probe_in = pick;
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                      pcrs_pkg::REG_DRIVE, pcrs_pkg::select_byte(pick), 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                      pcrs_pkg::REG_STATUS, 8'd0, 4'd0, 2'd0));
               phase_in = PH_PR_STATUS;
            end else if (!rpass_in) begin
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_DONE,
                      3'd0, 8'd0, found_in, 2'd0));
               phase_in = PH_IDLE;
            end else begin
               pending_in = found_in;
               rpass_in   = 1'b0;
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                      pcrs_pkg::REG_CONTROL, pcrs_pkg::CTRL_SRST, 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_STALL,
                      3'd0, 8'd0, 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                      pcrs_pkg::REG_CONTROL, pcrs_pkg::CTRL_RUN, 4'd0, 2'd0));
               b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_STALL,
                      3'd0, 8'd0, 4'd0, 2'd0));
               if (pending_in != 4'd0) begin
                  do_wait = 1'b1;
               end else begin
                  found_in = 4'd0;
                  start    = 3'd0;
                  do_probe = 1'b1;
               end
            end
         end
      end

      // Post-reset wait on the lowest pending target.
      if (do_wait) begin
         priority if (pending_in[0]) low_t = 2'd0;
         else if (pending_in[1])     low_t = 2'd1;
         else if (pending_in[2])     low_t = 2'd2;
         else                        low_t = 2'd3;
         current_in = low_t;
         if (low_t[0]) begin
            wait_in = sel_timeout_ff;
            b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                   pcrs_pkg::REG_DRIVE, pcrs_pkg::select_byte(low_t), 4'd0, 2'd0));
            b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                   pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_B, 4'd0, 2'd0));
            b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                   pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_A, 4'd0, 2'd0));
            b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_WRITE,
                   pcrs_pkg::REG_CNT_LO, pcrs_pkg::ECHO_B, 4'd0, 2'd0));
            b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                   pcrs_pkg::REG_CNT_LO, 8'd0, 4'd0, 2'd0));
            phase_in = PH_RA_READ;
         end else begin
            wait_in = bsy_timeout_ff;
            b = pcrs_pkg::rsp_push(b, pcrs_pkg::mk_rsp(pcrs_pkg::KIND_READ,
                   pcrs_pkg::REG_STATUS, 8'd0, 4'd0, 2'd0));
            phase_in = PH_WB_READ;
         end
      end

      if (b.count != '0) begin
         b.item[b.count - pcrs_pkg::RSP_CNT_W'(1)].last = 1'b1;
      end
      batch = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff <= 3'd2;
         bad_mask_ff     <= 4'd0;
         sel_timeout_ff  <= 16'd100;
         bsy_timeout_ff  <= 16'd1000;
         skip_drain_ff   <= 1'b0;
         phase_ff        <= PH_IDLE;
         probe_ff        <= 2'd0;
         found_ff        <= 4'd0;
         pending_ff      <= 4'd0;
         current_ff      <= 2'd0;
         wait_ff         <= 16'd0;
         drain_ff        <= '0;
         rpass_ff        <= 1'b0;
         in_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               pcrs_pkg::CSR_TARGET_COUNT: target_count_ff <= csr_wdata[2:0];
               pcrs_pkg::CSR_BAD_MASK:     bad_mask_ff     <= csr_wdata[3:0];
               pcrs_pkg::CSR_SEL_TIMEOUT:  sel_timeout_ff  <= csr_wdata;
               pcrs_pkg::CSR_BSY_TIMEOUT:  bsy_timeout_ff  <= csr_wdata;
               pcrs_pkg::CSR_SKIP_DRAIN:   skip_drain_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (take) begin
            phase_ff   <= phase_in;
            probe_ff   <= probe_in;
            found_ff   <= found_in;
            pending_ff <= pending_in;
            current_ff <= current_in;
            wait_ff    <= wait_in;
            drain_ff   <= drain_in;
            rpass_ff   <= rpass_in;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
            in_ff       <= req_payload;
         end
      end
   end

   pcrs_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .load        (take),
      .batch       (batch),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hw/rtl/pcrs_checker.sv */
module pcrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pcrs_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // done and failure close a request's results
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == pcrs_pkg::KIND_DONE ||
                    rsp_payload.kind == pcrs_pkg::KIND_FAIL) |-> rsp_payload.last)
      else $error("done or failure not marked last");

   a_ctrl_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == pcrs_pkg::KIND_WRITE &&
      rsp_payload.reg_select == pcrs_pkg::REG_CONTROL |->
      rsp_payload.write_value == pcrs_pkg::CTRL_SRST ||
      rsp_payload.write_value == pcrs_pkg::CTRL_RUN)
      else $error("bad control write");

   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == pcrs_pkg::KIND_DONE |->
      rsp_payload.reg_select == 3'd0 && rsp_payload.write_value == 8'd0 &&
      rsp_payload.failed_target == 2'd0)
      else $error("done carries stray fields");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind pata_channel_reset_sequencer pcrs_checker u_pcrs_checker (.*);
